// ----- src/i2cms_pkg.sv -----
// shared types for the i2c master bit sequencer
package i2cms_pkg;

    typedef enum logic [2:0] {
        MODE_START    = 3'd0,
        MODE_STOP     = 3'd1,
        MODE_WRITE    = 3'd2,
        MODE_READ     = 3'd3,
        MODE_WAIT_ACK = 3'd4
    } mode_t;

    typedef struct packed {
        mode_t      mode;
        logic [7:0] write_data;
        logic       send_nack;
        logic [7:0] slave_bits;
        logic       slave_ack_level;
    } cmd_t;

    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       sda_released;
        logic       hold;
        logic [7:0] rx_byte;
        logic       ack_missing;
        logic       last;
    } bus_state_t;

    localparam int unsigned STEP_W = 5;

endpackage

// ----- src/i2cms_front.sv -----
// front stage: takes requests, drops unknown modes, hands commands to the queue
module i2cms_front
    import i2cms_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [2:0]  s_tuser,
    input  logic [23:0] s_tdata,
    output logic        push,
    output cmd_t        push_cmd,
    input  logic        q_ready
);

    logic cmd_valid_reg;
    cmd_t cmd_reg;
    logic known;

    always_comb begin
        case (s_tuser)
            MODE_START, MODE_STOP, MODE_WRITE, MODE_READ, MODE_WAIT_ACK: known = 1'b1;
            default: known = 1'b0;
        endcase
    end

    assign s_tready = !cmd_valid_reg || q_ready;
    assign push     = cmd_valid_reg && q_ready;
    assign push_cmd = cmd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_valid_reg <= 1'b0;
        end else if (s_tready) begin
            // unknown modes give no bus states at all
            cmd_valid_reg <= s_tvalid && known;
        end
        if (s_tready && s_tvalid) begin
            cmd_reg.mode            <= mode_t'(s_tuser);
            cmd_reg.write_data      <= s_tdata[7:0];
            cmd_reg.send_nack       <= s_tdata[8];
            cmd_reg.slave_bits      <= s_tdata[16:9];
            cmd_reg.slave_ack_level <= s_tdata[17];
        end
    end

endmodule

// ----- src/i2cms_queue.sv -----
// short command queue between front and back
module i2cms_queue
    import i2cms_pkg::*;
#(
    parameter int unsigned DEPTH = 4
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    output logic q_ready,
    input  logic pop,
    output logic q_valid,
    output cmd_t q_cmd
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    cmd_t            entry_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg;
    logic [AW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   count_reg;

    assign q_ready = count_reg != CW'(DEPTH);
    assign q_valid = count_reg != '0;
    assign q_cmd   = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ----- src/i2cms_back.sv -----
// back stage: steps through the bus states of the head command, one per cycle while the output is not stalled
module i2cms_back
    import i2cms_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       q_valid,
    input  cmd_t       q_cmd,
    output logic       pop,
    output logic       m_tvalid,
    input  logic       m_tready,
    output bus_state_t out_state
);

    logic [STEP_W-1:0] step_reg;
    logic              sda_level_reg;
    logic              dir_in_reg;
    logic              out_valid_reg;
    bus_state_t        out_reg;

    logic              scl_e;
    logic              sda_e;
    logic              rel_e;
    logic              hold_e;
    logic              last_e;
    logic              miss_e;
    logic [7:0]        rdata_e;
    logic [STEP_W-1:0] bit_step;
    logic [2:0]        k;
    logic [2:0]        bit_idx;
    logic [2:0]        next_idx;
    logic              adv;
    bus_state_t        out_next;

    assign bit_step = step_reg - STEP_W'(2);
    assign k        = bit_step[3:1];
    assign bit_idx  = 3'd7 - k;
    assign next_idx = (k == 3'd7) ? 3'd0 : 3'd6 - k;

    always_comb begin
        scl_e   = 1'b0;
        sda_e   = 1'b1;
        rel_e   = 1'b0;
        hold_e  = 1'b0;
        last_e  = 1'b0;
        miss_e  = 1'b0;
        rdata_e = '0;
        if (step_reg == '0) begin
            // every command opens by pulling scl low, lines otherwise as left
            sda_e = sda_level_reg;
            rel_e = dir_in_reg;
        end else begin
            case (q_cmd.mode)
                MODE_START: begin
                    case (step_reg)
                        5'd1: begin scl_e = 1'b0; sda_e = 1'b1; end
                        5'd2: begin scl_e = 1'b1; sda_e = 1'b1; hold_e = 1'b1; end
                        5'd3: begin scl_e = 1'b1; sda_e = 1'b0; hold_e = 1'b1; end
                        default: begin scl_e = 1'b0; sda_e = 1'b0; last_e = 1'b1; end
                    endcase
                end
                MODE_STOP: begin
                    case (step_reg)
                        5'd1: begin scl_e = 1'b0; sda_e = 1'b0; end
                        5'd2: begin scl_e = 1'b1; sda_e = 1'b0; hold_e = 1'b1; end
                        default: begin
                            scl_e = 1'b1; sda_e = 1'b1; hold_e = 1'b1; last_e = 1'b1;
                        end
                    endcase
                end
                MODE_WRITE: begin
                    if (step_reg == 5'd1) begin
                        sda_e = q_cmd.write_data[7];
                    end else if (!step_reg[0]) begin
                        scl_e  = 1'b1;
                        sda_e  = q_cmd.write_data[bit_idx];
                        hold_e = 1'b1;
                    end else begin
                        // next bit set up during the low phase
                        sda_e  = q_cmd.write_data[next_idx];
                        hold_e = 1'b1;
                        last_e = step_reg == 5'd17;
                    end
                end
                MODE_READ: begin
                    if (step_reg == 5'd1) begin
                        rel_e = 1'b1;
                    end else if (step_reg <= 5'd17) begin
                        scl_e  = !step_reg[0];
                        rel_e  = 1'b1;
                        hold_e = 1'b1;
                    end else begin
                        case (step_reg)
                            5'd18: begin sda_e = q_cmd.send_nack; end
                            5'd19: begin
                                scl_e = 1'b1; sda_e = q_cmd.send_nack; hold_e = 1'b1;
                            end
                            default: begin
                                sda_e   = q_cmd.send_nack;
                                last_e  = 1'b1;
                                rdata_e = q_cmd.slave_bits;
                            end
                        endcase
                    end
                end
                MODE_WAIT_ACK: begin
                    case (step_reg)
                        5'd1: begin rel_e = 1'b1; end
                        5'd2: begin
                            scl_e = 1'b1; rel_e = 1'b1; hold_e = 1'b1;
                            last_e = !q_cmd.slave_ack_level;
                        end
                        5'd3: begin rel_e = 1'b1; end
                        5'd4: begin sda_e = 1'b0; end
                        5'd5: begin scl_e = 1'b1; sda_e = 1'b0; hold_e = 1'b1; end
                        default: begin
                            // nack: stop issued straight away
                            scl_e = 1'b1; hold_e = 1'b1; last_e = 1'b1; miss_e = 1'b1;
                        end
                    endcase
                end
                default: begin
                    last_e = 1'b1;
                end
            endcase
        end
    end

    always_comb begin
        out_next.scl          = scl_e;
        out_next.sda          = rel_e | sda_e;
        out_next.sda_released = rel_e;
        out_next.hold         = hold_e;
        out_next.rx_byte      = rdata_e;
        out_next.ack_missing  = miss_e;
        out_next.last         = last_e;
    end

    assign adv       = q_valid && (!out_valid_reg || m_tready);
    assign pop       = adv && last_e;
    assign m_tvalid  = out_valid_reg;
    assign out_state = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg      <= '0;
            sda_level_reg <= 1'b1;
            dir_in_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (adv) begin
                step_reg      <= last_e ? '0 : step_reg + 1'b1;
                sda_level_reg <= sda_e;
                dir_in_reg    <= rel_e;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
        if (adv) begin
            out_reg <= out_next;
        end
    end

endmodule

// ----- src/i2c_master_bit_sequencer.sv -----
// i2c master bit sequencer: one request in, a run of bus states out, one state per cycle if not stalled
// a request passes the front command register, the queue and the back output register
// throughput: one bus state per cycle while m_tready is high; a request gives 3 to 21
//   states (start 5, stop 4, write 18, read 21, wait ack 3 or 7), set by the back stepper
// unknown modes are dropped in the front stage and give no state
// reset: sda level 1 with the master driving, queue empty, half period 500
module i2c_master_bit_sequencer
    import i2cms_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // write_data[7:0], send_nack, slave_bits[7:0], slave_ack_level
    input  logic [2:0]  s_tuser,   // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // scl, sda, sda_released, hold, rx_byte[7:0], ack_missing
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic       push;
    cmd_t       push_cmd;
    logic       q_ready;
    logic       pop;
    logic       q_valid;
    cmd_t       q_cmd;
    bus_state_t out_state;
    logic [15:0] half_period_reg;

    i2cms_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .push     (push),
        .push_cmd (push_cmd),
        .q_ready  (q_ready)
    );

    i2cms_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .q_ready  (q_ready),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd)
    );

    i2cms_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .out_state (out_state)
    );

    assign m_tdata = {3'b000, out_state.ack_missing, out_state.rx_byte, out_state.hold,
                      out_state.sda_released, out_state.sda, out_state.scl};
    assign m_tlast = out_state.last;

    // half period register is held for software, it does not shape the states
    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {16'h0000, half_period_reg} : 32'h0000_0000;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_period_reg <= 16'd500;
        end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
            half_period_reg <= pwdata[15:0];
        end
    end

endmodule
